/* hw/rtl/multichannel_to_stereo_downmix_unit_defines.svh */
// Assertion macros used by the checker file of the downmix block.
`ifndef MULTICHANNEL_TO_STEREO_DOWNMIX_UNIT_DEFINES_SVH
`define MULTICHANNEL_TO_STEREO_DOWNMIX_UNIT_DEFINES_SVH

// A clocked property that is checked only while reset is released.
`define DMX_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("downmix assertion failed");

// A signal that must hold while its channel is stalled.
`define DMX_ASSERT_HOLD(lbl, clk, rstn, stall, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (stall) |=> $stable(sig)) \
		else $error("downmix payload changed during a stall");

`endif

/* hw/rtl/dmx_pkg.sv */
`timescale 1ns / 1ps

package dmx_pkg;

	// Largest channel count that is honored; larger settings are clamped.
	localparam int MAX_CHANNELS = 8;

	// Fixed field widths.
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 4;

	// Derived widths.
	localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int POS_W  = $clog2(MAX_CHANNELS);
	localparam int SUM_W  = SAMPLE_W + $clog2(MAX_CHANNELS);
	localparam int DCNT_W = $clog2(SUM_W + 1);

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_STEREO   = 2'd1,
		STATUS_MIDFRAME = 2'd2
	} status_t;

	// Start request to the divider.
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	// Divider result.
	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/dmx_div.sv */
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module dmx_div import dmx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    trial;
	logic              fits;

	// Shift the next dividend bit into the remainder and try a subtract.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, divisor_q}) : CNT_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* hw/rtl/multichannel_to_stereo_downmix_unit.sv */
`timescale 1ns / 1ps

// Stereo downmix of an interleaved stream of signed 16-bit samples. A sample
// that does not finish a frame is taken while the block stays idle. With one
// channel each sample gives a left and a right result. With three or more
// channels the last sample of a frame starts a bit-serial divide of the
// extra-channel sum by the channel count, which shifts out SUM_W (19) quotient
// bits and then reports its quotient. The left and right results follow, and
// the next sample is taken only after the right result has transferred. The
// input is not ready while a divide runs, while results wait, or while a
// channel count write is offered. Writing the channel count restarts the frame
// and is done only while the block is idle.
module multichannel_to_stereo_downmix_unit import dmx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Channel count register
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	// Input samples
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_value
	input  logic                s_tlast,   // end_of_buffer
	// Stereo results
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] out_sample
	output logic                m_tlast,   // end_flag
	output logic [2:0]          m_tuser    // [0] right_side, [2:1] status
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DIV      = 5'b00010,
		ST_SEND_L   = 5'b00100,
		ST_SEND_R   = 5'b01000,
		ST_SEND_ONE = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     chan_cfg_q;
	logic [POS_W-1:0]     pos_q;
	logic [SAMPLE_W-1:0]  left_src_q;
	logic [SAMPLE_W-1:0]  right_src_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 neg_q;
	logic                 end_q;
	status_t              status_q;
	logic [SAMPLE_W-1:0]  left_res_q;
	logic [SAMPLE_W-1:0]  right_res_q;

	logic [CNT_W-1:0]     n_eff;
	logic                 in_xfer;
	logic                 out_xfer;
	logic                 frame_last;
	logic [SUM_W-1:0]     sample_ext;
	logic [SUM_W-1:0]     new_sum;
	logic [SUM_W-1:0]     sum_mag;
	logic [SUM_W-1:0]     quo_signed;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	// Clamp the configured count to the supported maximum.
	assign n_eff = ({1'b0, chan_cfg_q} > (CFG_W + 1)'(MAX_CHANNELS)) ?
		CNT_W'(MAX_CHANNELS) : CNT_W'(chan_cfg_q);

	// A register write and a sample transfer never share a cycle.
	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = m_tvalid && m_tready;

	// Frame bookkeeping and the signed magnitude of the extra-channel sum.
	assign frame_last = (CNT_W'(pos_q) + CNT_W'(1)) >= n_eff;
	assign sample_ext = {{(SUM_W - SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
	assign new_sum    = sum_q + sample_ext;
	assign sum_mag    = new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
	assign quo_signed = neg_q ? (~div_rsp.quotient + SUM_W'(1)) : div_rsp.quotient;

	assign div_req.start    = in_xfer && (n_eff > CNT_W'(2)) && frame_last;
	assign div_req.dividend = sum_mag;
	assign div_req.divisor  = n_eff;

	dmx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control sequencer and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chan_cfg_q <= CFG_W'(1);
			pos_q      <= '0;
			sum_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			chan_cfg_q <= cfg_data;
			pos_q      <= '0;
			sum_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (n_eff == CNT_W'(0)) begin
							pos_q <= '0;
							sum_q <= '0;
						end else if (n_eff == CNT_W'(2)) begin
							pos_q <= '0;
							sum_q <= '0;
							if (s_tlast) begin
								state_q <= ST_SEND_ONE;
							end
						end else if (n_eff == CNT_W'(1)) begin
							pos_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SEND_L;
						end else if (!frame_last) begin
							if (s_tlast) begin
								pos_q   <= '0;
								sum_q   <= '0;
								state_q <= ST_SEND_ONE;
							end else begin
								pos_q <= pos_q + POS_W'(1);
								if (pos_q >= POS_W'(2)) begin
									sum_q <= new_sum;
								end
							end
						end else begin
							pos_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SEND_L;
					end
				end
				ST_SEND_L: begin
					if (out_xfer) begin
						state_q <= ST_SEND_R;
					end
				end
				ST_SEND_R, ST_SEND_ONE: begin
					if (out_xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample capture and result registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			end_q <= s_tlast;
			neg_q <= new_sum[SUM_W-1];
			if (n_eff == CNT_W'(2)) begin
				status_q <= STATUS_STEREO;
			end else begin
				status_q <= STATUS_MIDFRAME;
			end
			if (n_eff == CNT_W'(1)) begin
				left_res_q  <= s_tdata;
				right_res_q <= s_tdata;
			end
			if (pos_q == POS_W'(0)) begin
				left_src_q <= s_tdata;
			end
			if (pos_q == POS_W'(1)) begin
				right_src_q <= s_tdata;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			left_res_q  <= left_src_q + quo_signed[SAMPLE_W-1:0];
			right_res_q <= right_src_q + quo_signed[SAMPLE_W-1:0];
		end
	end

	// Output channel.
	always_comb begin
		m_tvalid = 1'b0;
		m_tdata  = '0;
		m_tlast  = 1'b0;
		m_tuser  = {STATUS_OK, 1'b0};
		case (state_q)
			ST_SEND_L: begin
				m_tvalid = 1'b1;
				m_tdata  = left_res_q;
			end
			ST_SEND_R: begin
				m_tvalid = 1'b1;
				m_tdata  = right_res_q;
				m_tlast  = end_q;
				m_tuser  = {STATUS_OK, 1'b1};
			end
			ST_SEND_ONE: begin
				m_tvalid = 1'b1;
				m_tlast  = 1'b1;
				m_tuser  = {status_q, 1'b0};
			end
			default: begin
				m_tvalid = 1'b0;
			end
		endcase
	end

endmodule

/* hw/rtl/dmx_checker.sv */
`timescale 1ns / 1ps

`include "multichannel_to_stereo_downmix_unit_defines.svh"

// Port-level checks of the downmix block.
module dmx_checker import dmx_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [SAMPLE_W-1:0] m_tdata,
	input logic                m_tlast,
	input logic [2:0]          m_tuser
);

	// No new sample is taken while a result waits.
	`DMX_ASSERT(a_no_accept_while_out, clk, arst_n, m_tvalid |-> !s_tready)

	// A stalled result keeps its data.
	`DMX_ASSERT_HOLD(a_hold_data, clk, arst_n, m_tvalid && !m_tready, m_tdata)

	// Status results are single and close the buffer.
	`DMX_ASSERT(a_status_last, clk, arst_n,
		(m_tvalid && (m_tuser[2:1] != STATUS_OK)) |-> (m_tlast && !m_tuser[0]))

	// A left result is always followed by its right result.
	`DMX_ASSERT(a_left_then_right, clk, arst_n,
		(m_tvalid && m_tready && !m_tuser[0] && (m_tuser[2:1] == STATUS_OK)) |=>
		(m_tvalid && m_tuser[0]))

endmodule

bind multichannel_to_stereo_downmix_unit dmx_checker u_dmx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
